// ===== rtl/core/mcalu_pkg.sv =====
// ----------------------------------------------------------------------------
// mcalu_pkg
// Types and constants shared by the execute-stage modules.
// ----------------------------------------------------------------------------
package mcalu_pkg;

  localparam int DIV_STEPS = 16;

  localparam logic [2:0] TRAP_NONE    = 3'd0;
  localparam logic [2:0] TRAP_ILLEGAL = 3'd1;
  localparam logic [2:0] TRAP_EMUL    = 3'd2;
  localparam logic [2:0] TRAP_SOFT    = 3'd3;
  localparam logic [2:0] TRAP_BREAK   = 3'd4;
  localparam logic [2:0] TRAP_IO      = 3'd5;

  localparam logic [15:0] MOST_NEG16 = 16'h8000;

  typedef enum logic [1:0] {
    KIND_ALU,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  typedef struct packed {
    logic [15:0] res;
    logic [15:0] pair;
    logic        wr;
    logic        wp;
    logic [3:0]  cc;
    logic        br;
    logic [8:0]  boff;
    logic [2:0]  trp;
  } exec_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] work;
    logic [15:0] dmag;
    logic        neg_q;
    logic        neg_r;
    logic        ovf;
  } div_t;

  typedef struct packed {
    exec_t       ex;
    kind_t       kind;
    logic        odd;
    logic [31:0] prod;
    div_t        dv;
  } pipe_t;

endpackage

// ===== rtl/core/mcalu_exec.sv =====
// ----------------------------------------------------------------------------
// mcalu_exec
// Decodes one instruction and computes every operation except the divide
// iterations and the final multiply and divide result selection.
// ----------------------------------------------------------------------------
module mcalu_exec (
  input  logic [15:0]            instruction,
  input  logic [15:0]            src_value,
  input  logic [15:0]            dst_value,
  input  logic [15:0]            reg_value,
  input  logic [15:0]            pair_low,
  input  logic [3:0]             cond_in,
  output mcalu_pkg::pipe_t       pipe
);

  localparam logic [15:0] G_JMP   = 16'o000100;
  localparam logic [15:0] G_RTS   = 16'o000200;
  localparam logic [15:0] G_SWAB  = 16'o000300;
  localparam logic [15:0] G_CLR   = 16'o005000;
  localparam logic [15:0] G_COM   = 16'o005100;
  localparam logic [15:0] G_INC   = 16'o005200;
  localparam logic [15:0] G_DEC   = 16'o005300;
  localparam logic [15:0] G_NEG   = 16'o005400;
  localparam logic [15:0] G_ADC   = 16'o005500;
  localparam logic [15:0] G_SBC   = 16'o005600;
  localparam logic [15:0] G_TST   = 16'o005700;
  localparam logic [15:0] G_ROR   = 16'o006000;
  localparam logic [15:0] G_ROL   = 16'o006100;
  localparam logic [15:0] G_ASR   = 16'o006200;
  localparam logic [15:0] G_ASL   = 16'o006300;
  localparam logic [15:0] G_MFPI  = 16'o006500;
  localparam logic [15:0] G_SXT   = 16'o006700;
  localparam logic [15:0] K_BR    = 16'o000400;
  localparam logic [15:0] K_BNE   = 16'o001000;
  localparam logic [15:0] K_BEQ   = 16'o001400;
  localparam logic [15:0] K_BGE   = 16'o002000;
  localparam logic [15:0] K_BLT   = 16'o002400;
  localparam logic [15:0] K_BGT   = 16'o003000;
  localparam logic [15:0] K_BLE   = 16'o003400;
  localparam logic [15:0] K_BPL   = 16'o100000;
  localparam logic [15:0] K_BMI   = 16'o100400;
  localparam logic [15:0] K_BHI   = 16'o101000;
  localparam logic [15:0] K_BLOS  = 16'o101400;
  localparam logic [15:0] K_BVC   = 16'o102000;
  localparam logic [15:0] K_BVS   = 16'o102400;
  localparam logic [15:0] K_BCC   = 16'o103000;
  localparam logic [15:0] K_BCS   = 16'o103400;
  localparam logic [15:0] K_EMT   = 16'o104000;
  localparam logic [15:0] K_TRAP  = 16'o104400;
  localparam logic [15:0] K_MARK  = 16'o006400;
  localparam logic [15:0] IW_BPT  = 16'd3;
  localparam logic [15:0] IW_IOT  = 16'd4;
  localparam logic [15:0] IW_LAST = 16'd6;
  localparam logic [6:0]  JSR_HI  = 7'b0000100;
  localparam logic [2:0]  OP_MOV  = 3'd1;
  localparam logic [2:0]  OP_CMP  = 3'd2;
  localparam logic [2:0]  OP_BIT  = 3'd3;
  localparam logic [2:0]  OP_BIC  = 3'd4;
  localparam logic [2:0]  OP_BIS  = 3'd5;
  localparam logic [2:0]  OP_ADD  = 3'd6;
  localparam logic [2:0]  OP_EIS  = 3'd7;
  localparam logic [2:0]  SUB_MUL = 3'd0;
  localparam logic [2:0]  SUB_DIV = 3'd1;
  localparam logic [2:0]  SUB_ASH = 3'd2;
  localparam logic [2:0]  SUB_ASHC = 3'd3;
  localparam logic [2:0]  SUB_XOR = 3'd4;
  localparam logic [2:0]  SUB_SOB = 3'd7;

  logic signed [31:0] prod;

  assign prod = $signed(reg_value) * $signed(src_value);

  always_comb begin
    logic        bsel, n, z, v, c, cin, wide;
    logic [15:0] mk, sg, g, key, a, b, r, d;
    logic [2:0]  op, sub, rn, dmode;
    logic [5:0]  m2, cnt;
    logic [3:0]  cc;
    logic [16:0] sum;
    logic [31:0] w32, xl, wres, shl, vmask, num, nmag;
    logic [63:0] ext64, shr;
    logic [6:0]  kk;
    logic        t_valid, t_val;
    mcalu_pkg::exec_t ex;
    mcalu_pkg::div_t  dvs;
    mcalu_pkg::kind_t kind;

    bsel  = instruction[15];
    mk    = bsel ? 16'h00FF : 16'hFFFF;
    sg    = bsel ? 16'h0080 : 16'h8000;
    op    = instruction[14:12];
    sub   = instruction[11:9];
    rn    = instruction[8:6];
    dmode = instruction[5:3];
    m2    = instruction[5:0];
    g     = instruction & 16'o077700;
    key   = instruction & 16'o177400;
    cc    = cond_in;
    n     = cc[3];
    z     = cc[2];
    v     = cc[1];
    c     = cc[0];
    cin   = c;
    kind  = mcalu_pkg::KIND_ALU;
    ex    = '0;
    dvs   = '0;
    a     = src_value & mk;
    b     = dst_value & mk;
    d     = dst_value & mk;
    r     = '0;
    sum   = '0;
    wide  = (sub == SUB_ASHC);
    w32   = {reg_value, rn[0] ? reg_value : pair_low};
    xl    = wide ? w32 : {reg_value, 16'h0000};
    ext64 = wide ? {{32{w32[31]}}, w32} : {{48{reg_value[15]}}, reg_value};
    cnt   = src_value[5:0];
    kk    = 7'd64 - {1'b0, cnt};
    shr   = ext64 >> kk;
    shl   = xl << cnt;
    vmask = (~(32'hFFFF_FFFF >> cnt)) >> 1;
    wres  = '0;
    num   = {reg_value, pair_low};
    nmag  = num[31] ? (32'd0 - num) : num;
    t_valid = 1'b0;
    t_val   = 1'b0;

    if (op >= OP_MOV && op <= OP_BIS) begin
      case (op)
        OP_MOV: begin
          r = a;
          if (bsel && dmode == 3'd0 && a[7]) begin
            r = a | 16'hFF00;
          end
          ex.wr = 1'b1;
          v = 1'b0;
        end
        OP_CMP: begin
          r = (a - b) & mk;
          v = |((a ^ b) & (a ^ r) & sg);
          c = b > a;
        end
        OP_BIT: begin
          r = a & b;
          v = 1'b0;
        end
        OP_BIC: begin
          r = b & ~a & mk;
          v = 1'b0;
          ex.wr = 1'b1;
        end
        default: begin
          r = (a | b) & mk;
          v = 1'b0;
          ex.wr = 1'b1;
        end
      endcase
      n = |(r & sg);
      z = (r & mk) == 16'd0;
      if (ex.wr) begin
        ex.res = r;
      end
    end else if (op == OP_ADD) begin
      if (bsel) begin
        r = dst_value - src_value;
        v = ((dst_value ^ src_value) & (dst_value ^ r)) >> 15 != 16'd0;
        c = src_value > dst_value;
      end else begin
        sum = {1'b0, src_value} + {1'b0, dst_value};
        c = sum[16];
        r = sum[15:0];
        v = ((~(src_value ^ dst_value)) & (src_value ^ r)) >> 15 != 16'd0;
      end
      n = r[15];
      z = r == 16'd0;
      ex.res = r;
      ex.wr = 1'b1;
    end else if (op == OP_EIS) begin
      if (bsel) begin
        ex.trp = mcalu_pkg::TRAP_ILLEGAL;
      end else begin
        case (sub)
          SUB_MUL: begin
            kind = mcalu_pkg::KIND_MUL;
          end
          SUB_DIV: begin
            n = 1'b0;
            z = 1'b0;
            v = 1'b0;
            c = 1'b0;
            if (src_value == 16'd0) begin
              v = 1'b1;
              c = 1'b1;
            end else if (rn[0]) begin
              v = 1'b1;
            end else begin
              kind = mcalu_pkg::KIND_DIV;
              dvs.neg_r = num[31];
              dvs.neg_q = num[31] ^ src_value[15];
              dvs.dmag  = src_value[15] ? (16'd0 - src_value) : src_value;
              dvs.ovf   = nmag[31:16] >= dvs.dmag;
              dvs.rem   = nmag[31:16];
              dvs.work  = nmag[15:0];
            end
          end
          SUB_ASH, SUB_ASHC: begin
            if (cnt[5]) begin
              wres = shr[31:0];
              c = ext64[6'(kk - 7'd1)];
              v = 1'b0;
              r = wres[15:0];
            end else begin
              wres = shl;
              c = (cnt == 6'd0) ? 1'b0 : xl[5'(6'd32 - cnt)];
              v = |((xl ^ {32{xl[31]}}) & vmask);
              r = wres[31:16];
            end
            if (!wide) begin
              n = r[15];
              z = r == 16'd0;
              ex.res = r;
              ex.wr = 1'b1;
            end else begin
              n = wres[31];
              z = wres == 32'd0;
              ex.wr = 1'b1;
              if (!rn[0]) begin
                ex.res = wres[31:16];
                ex.pair = wres[15:0];
                ex.wp = 1'b1;
              end else begin
                ex.res = wres[15:0];
              end
            end
          end
          SUB_XOR: begin
            r = reg_value ^ dst_value;
            n = r[15];
            z = r == 16'd0;
            v = 1'b0;
            ex.res = r;
            ex.wr = 1'b1;
          end
          SUB_SOB: begin
            r = reg_value - 16'd1;
            ex.res = r;
            ex.wr = 1'b1;
            if (r != 16'd0) begin
              ex.br = 1'b1;
              ex.boff = 9'd0 - {2'b00, m2, 1'b0};
            end
          end
          default: begin
            ex.trp = mcalu_pkg::TRAP_ILLEGAL;
          end
        endcase
      end
    end else if (!bsel && instruction[15:9] == JSR_HI) begin
      if (dmode == 3'd0) begin
        ex.trp = mcalu_pkg::TRAP_ILLEGAL;
      end
    end else if (!bsel && (g == G_JMP || g == G_RTS || g == G_SWAB)) begin
      if (g == G_JMP) begin
        if (dmode == 3'd0) begin
          ex.trp = mcalu_pkg::TRAP_ILLEGAL;
        end
      end else if (g == G_RTS) begin
        if (m2 >= 6'o40) begin
          if (instruction[4]) begin
            cc = cc | instruction[3:0];
          end else begin
            cc = cc & ~instruction[3:0];
          end
          n = cc[3];
          z = cc[2];
          v = cc[1];
          c = cc[0];
        end else if (m2 >= 6'o10) begin
          ex.trp = mcalu_pkg::TRAP_ILLEGAL;
        end
      end else begin
        r = {dst_value[7:0], dst_value[15:8]};
        n = r[7];
        z = r[7:0] == 8'd0;
        v = 1'b0;
        c = 1'b0;
        ex.res = r;
        ex.wr = 1'b1;
      end
    end else if (g >= G_CLR && g <= G_ASL) begin
      case (g)
        G_CLR: begin
          r = '0;
          c = 1'b0;
        end
        G_COM: begin
          r = ~d & mk;
          c = 1'b1;
        end
        G_INC: begin
          r = (d + 16'd1) & mk;
          v = r == sg;
        end
        G_DEC: begin
          r = (d - 16'd1) & mk;
          v = r == (mk - sg);
        end
        G_NEG: begin
          r = (16'd0 - d) & mk;
          v = r == sg;
          c = r != 16'd0;
        end
        G_ADC: begin
          r = (d + {15'd0, cin}) & mk;
          v = cin && d == (mk - sg);
          c = cin && d == mk;
        end
        G_SBC: begin
          r = (d - {15'd0, cin}) & mk;
          v = d == sg;
          c = cin && d == 16'd0;
        end
        G_TST: begin
          r = d;
          c = 1'b0;
        end
        G_ROR: begin
          r = (d >> 1) | (cin ? sg : 16'd0);
          c = d[0];
        end
        G_ROL: begin
          r = ((d << 1) | {15'd0, cin}) & mk;
          c = |(d & sg);
        end
        G_ASR: begin
          r = (d >> 1) | (d & sg);
          c = d[0];
        end
        default: begin
          r = (d << 1) & mk;
          c = |(d & sg);
        end
      endcase
      n = |(r & sg);
      z = r == 16'd0;
      if (g == G_CLR || g == G_COM || g == G_TST) begin
        v = 1'b0;
      end else if (g >= G_ROR) begin
        v = n ^ c;
      end
      if (g != G_TST) begin
        ex.res = r;
        ex.wr = 1'b1;
      end
    end else if (g >= G_MFPI && g <= G_SXT) begin
      if (bsel) begin
        ex.trp = mcalu_pkg::TRAP_ILLEGAL;
      end else if (g == G_SXT) begin
        ex.res = n ? 16'hFFFF : 16'h0000;
        ex.wr = 1'b1;
        z = !n;
        v = 1'b0;
      end
    end else begin
      case (key)
        K_BR: begin
          t_valid = 1'b1;
          t_val = 1'b1;
        end
        K_BNE: begin
          t_valid = 1'b1;
          t_val = !z;
        end
        K_BEQ: begin
          t_valid = 1'b1;
          t_val = z;
        end
        K_BGE: begin
          t_valid = 1'b1;
          t_val = n == v;
        end
        K_BLT: begin
          t_valid = 1'b1;
          t_val = n != v;
        end
        K_BGT: begin
          t_valid = 1'b1;
          t_val = (n == v) && !z;
        end
        K_BLE: begin
          t_valid = 1'b1;
          t_val = (n != v) || z;
        end
        K_BPL: begin
          t_valid = 1'b1;
          t_val = !n;
        end
        K_BMI: begin
          t_valid = 1'b1;
          t_val = n;
        end
        K_BHI: begin
          t_valid = 1'b1;
          t_val = !c && !z;
        end
        K_BLOS: begin
          t_valid = 1'b1;
          t_val = c || z;
        end
        K_BVC: begin
          t_valid = 1'b1;
          t_val = !v;
        end
        K_BVS: begin
          t_valid = 1'b1;
          t_val = v;
        end
        K_BCC: begin
          t_valid = 1'b1;
          t_val = !c;
        end
        K_BCS: begin
          t_valid = 1'b1;
          t_val = c;
        end
        K_EMT: begin
          ex.trp = mcalu_pkg::TRAP_EMUL;
        end
        K_TRAP: begin
          ex.trp = mcalu_pkg::TRAP_SOFT;
        end
        K_MARK: begin
          ex.trp = mcalu_pkg::TRAP_NONE;
        end
        default: begin
          if (instruction == IW_BPT) begin
            ex.trp = mcalu_pkg::TRAP_BREAK;
          end else if (instruction == IW_IOT) begin
            ex.trp = mcalu_pkg::TRAP_IO;
          end else if (instruction > IW_LAST) begin
            ex.trp = mcalu_pkg::TRAP_ILLEGAL;
          end
        end
      endcase
      if (t_valid && t_val) begin
        ex.br = 1'b1;
        ex.boff = {instruction[7:0], 1'b0};
      end
    end

    ex.cc = {n, z, v, c};
    if (ex.trp != mcalu_pkg::TRAP_NONE) begin
      ex.res  = '0;
      ex.pair = '0;
      ex.wr   = 1'b0;
      ex.wp   = 1'b0;
      ex.br   = 1'b0;
      ex.boff = '0;
      ex.cc   = cond_in;
      kind    = mcalu_pkg::KIND_ALU;
    end

    pipe.ex   = ex;
    pipe.kind = kind;
    pipe.odd  = rn[0];
    pipe.prod = prod;
    pipe.dv   = dvs;
  end

endmodule

// ===== rtl/core/mcalu_div_stage.sv =====
// ----------------------------------------------------------------------------
// mcalu_div_stage
// One registered restoring-divide step; the rest of the item rides along.
// ----------------------------------------------------------------------------
module mcalu_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  mcalu_pkg::pipe_t pipe_in,
  output logic             valid_out,
  output mcalu_pkg::pipe_t pipe_out
);

  logic             valid_r;
  mcalu_pkg::pipe_t pipe_r;
  mcalu_pkg::pipe_t pipe_nxt;

  always_comb begin
    logic [16:0] rem2;
    logic [16:0] dext;
    logic        ge;

    rem2 = {pipe_in.dv.rem, pipe_in.dv.work[15]};
    dext = {1'b0, pipe_in.dv.dmag};
    ge   = rem2 >= dext;
    pipe_nxt = pipe_in;
    pipe_nxt.dv.rem  = ge ? 16'(rem2 - dext) : rem2[15:0];
    pipe_nxt.dv.work = {pipe_in.dv.work[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign valid_out = valid_r;
  assign pipe_out  = pipe_r;

endmodule

// ===== rtl/core/minicomputer_alu_condition_codes_top.sv =====
// ----------------------------------------------------------------------------
// minicomputer_alu_condition_codes_top
// Pipelined execute stage of a 16-bit minicomputer with condition codes.
// ----------------------------------------------------------------------------
// Each input beat carries one instruction with its fetched operands, the
// rn and rn+1 register contents and the current N Z V C codes. Each output
// beat carries the write-back values and enables, the new codes, the branch
// decision with its byte offset and a trap code.
// The pipeline has an input register, a decode and execute stage with the
// multiplier, sixteen restoring divide steps and an output register. One
// beat is accepted every cycle while the output is drained; the divide steps
// set the depth. When the receiver stalls with a result held on the output,
// the whole pipeline freezes and in_tready drops in the same cycle; nothing
// is lost or repeated. Reset clears every valid bit, so the output channel
// is empty after reset and the block accepts beats in the next cycle.
// ----------------------------------------------------------------------------
module minicomputer_alu_condition_codes_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // instruction, src_value, dst_value, reg_value, pair_low, cond_in, zero pad
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result, pair_result, write_result, write_pair, cond_out, branch_taken,
  // branch_offset, trap_code, zero pad
  output logic [55:0] out_tdata
);

  logic              en;
  logic              v1_r;
  logic [83:0]       in_r;
  mcalu_pkg::pipe_t  ex_pipe;
  logic              v2_r;
  mcalu_pkg::pipe_t  p2_r;
  logic              stage_v [0:mcalu_pkg::DIV_STEPS];
  mcalu_pkg::pipe_t  stage_d [0:mcalu_pkg::DIV_STEPS];
  mcalu_pkg::exec_t  fin_nxt;
  mcalu_pkg::exec_t  out_r;
  logic              out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_tdata[83:0];
      p2_r <= ex_pipe;
    end
  end

  mcalu_exec u_exec (
    .instruction (in_r[15:0]),
    .src_value   (in_r[31:16]),
    .dst_value   (in_r[47:32]),
    .reg_value   (in_r[63:48]),
    .pair_low    (in_r[79:64]),
    .cond_in     (in_r[83:80]),
    .pipe        (ex_pipe)
  );

  assign stage_v[0] = v2_r;
  assign stage_d[0] = p2_r;

  for (genvar i = 0; i < mcalu_pkg::DIV_STEPS; i++) begin : g_div
    mcalu_div_stage u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (stage_v[i]),
      .pipe_in   (stage_d[i]),
      .valid_out (stage_v[i+1]),
      .pipe_out  (stage_d[i+1])
    );
  end

  always_comb begin
    mcalu_pkg::pipe_t p;
    logic [15:0]      qm;
    logic             bad;

    p   = stage_d[mcalu_pkg::DIV_STEPS];
    qm  = p.dv.work;
    bad = p.dv.ovf || (!p.dv.neg_q && qm[15]) ||
          (p.dv.neg_q && qm > mcalu_pkg::MOST_NEG16);
    fin_nxt = p.ex;
    case (p.kind)
      mcalu_pkg::KIND_MUL: begin
        fin_nxt.cc = {p.prod[31], p.prod == 32'd0, 1'b0,
                      !((&p.prod[31:15]) || (~|p.prod[31:15]))};
        fin_nxt.wr = 1'b1;
        if (!p.odd) begin
          fin_nxt.res  = p.prod[31:16];
          fin_nxt.pair = p.prod[15:0];
          fin_nxt.wp   = 1'b1;
        end else begin
          fin_nxt.res = p.prod[15:0];
        end
      end
      mcalu_pkg::KIND_DIV: begin
        if (bad) begin
          fin_nxt.cc = 4'b0010;
        end else begin
          fin_nxt.res  = p.dv.neg_q ? (16'd0 - qm) : qm;
          fin_nxt.pair = p.dv.neg_r ? (16'd0 - p.dv.rem) : p.dv.rem;
          fin_nxt.wr   = 1'b1;
          fin_nxt.wp   = 1'b1;
          fin_nxt.cc   = {p.dv.neg_q && qm != 16'd0, qm == 16'd0, 2'b00};
        end
      end
      default: begin
        fin_nxt = p.ex;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage_v[mcalu_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= fin_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.trp, out_r.boff, out_r.br, out_r.cc,
                       out_r.wp, out_r.wr, out_r.pair, out_r.res};

  a_trap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[50:48] != mcalu_pkg::TRAP_NONE |->
      !out_tdata[32] && !out_tdata[33] && !out_tdata[38])
    else $error("trap beat carries a write or branch");

  a_offset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[38] |-> out_tdata[47:39] == 9'd0)
    else $error("offset set without a taken branch");

  a_pair_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[32])
    else $error("pair write without result write");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output is free");

endmodule
